FILE: rtl/plin_pkg.sv
// ----------------------------------------------------------------------------
// plin_pkg: shared types and constants for the positional list
// Field widths, opcode and status codes, and the per-cell shift command.
// ----------------------------------------------------------------------------
package plin_pkg;

   localparam int DATA_W       = 32;
   localparam int OPCODE_W     = 2;
   localparam int POS_W        = 5;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 5;
   localparam int CAPACITY_DEF = 16;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // what a cell loads this cycle
   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_LOAD  = 3'd1,   // new request value
      CELL_LEFT  = 3'd2,   // from lower neighbor (insert shift)
      CELL_RIGHT = 3'd3,   // from upper neighbor (delete shift, rotate)
      CELL_HEAD  = 3'd4    // from cell 0 (ring wrap on rotate)
   } cell_op_type;

endpackage

FILE: rtl/plin_cell.sv
// ----------------------------------------------------------------------------
// plin_cell: one storage cell of the list row
// Holds one entry and takes the value of a neighbor, the head or a new value.
// ----------------------------------------------------------------------------
module plin_cell (
   input  logic                                   clock,
   input  plin_pkg::cell_op_type                  op,
   input  logic signed [plin_pkg::DATA_W-1:0]     new_val,
   input  logic signed [plin_pkg::DATA_W-1:0]     left_val,
   input  logic signed [plin_pkg::DATA_W-1:0]     right_val,
   input  logic signed [plin_pkg::DATA_W-1:0]     head_val,
   output logic signed [plin_pkg::DATA_W-1:0]     entry
);
   import plin_pkg::*;

   logic signed [DATA_W-1:0] entry_ff;
   logic signed [DATA_W-1:0] entry_in;

   always_comb begin
      case (op)
         CELL_HOLD:  entry_in = entry_ff;
         CELL_LOAD:  entry_in = new_val;
         CELL_LEFT:  entry_in = left_val;
         CELL_RIGHT: entry_in = right_val;
         CELL_HEAD:  entry_in = head_val;
         default:    entry_in = entry_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: rtl/positional_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top: ordered list in a shifting row of cells
// Insert and delete by 1-based position, read streams the whole list.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  opcode, position, value
//   rsp_     out        rsp_valid/rsp_stall  status, data_out, count_out,
//                                            last_result
//
// Insert, delete, error cases and the unused opcode each give one response in
// the following cycle; a new request is taken every cycle while the response
// register drains.
// Read of N entries holds the request side: once the request is taken, the
// row rotates one entry to cell 0 per cycle while the response is not stalled,
// and after N steps the ring is back in its original order. No new request is
// taken while a read streams.
// Reset clears the entry count, the read state and the response valid; the
// cells themselves are not reset and only entries below the count are seen.
// A stalled response holds and stops the read stream and new requests.
//
module positional_list_insert_delete_top #(
   parameter int CAPACITY = plin_pkg::CAPACITY_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [plin_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [plin_pkg::POS_W-1:0]              req_position,
   input  logic signed [plin_pkg::DATA_W-1:0]      req_value,
   // response channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic [plin_pkg::STATUS_W-1:0]           rsp_status,
   output logic signed [plin_pkg::DATA_W-1:0]      rsp_data_out,
   output logic [plin_pkg::COUNT_OUT_W-1:0]        rsp_count_out,
   output logic                                    rsp_last_result
);
   import plin_pkg::*;

   // count holds 0..CAPACITY; compares run one bit wider than either operand
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // list state
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       reading_ff, reading_in;
   logic [CNT_W-1:0]           read_left_ff, read_left_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0]   rsp_data_out_ff, rsp_data_out_in;
   logic [COUNT_OUT_W-1:0]     rsp_count_out_ff, rsp_count_out_in;
   logic                       rsp_last_result_ff, rsp_last_result_in;

   logic                       out_free;
   logic                       req_accept;
   logic                       do_insert, do_delete, do_rotate;
   logic [CMP_W-1:0]           cnt_ext, pos_ext, idx_k;
   opcode_type                 req_op;

   logic signed [DATA_W-1:0]   entry_vals [CAPACITY];

   // response slot is free when empty or being taken this edge
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = reading_ff || !out_free;
   assign req_accept = req_valid && !req_stall;

   assign req_op  = opcode_type'(req_opcode);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_ext = CMP_W'(req_position);
   assign idx_k   = pos_ext - CMP_W'(1);

   // ---------------------------------------------------------------
   // request decode and response build
   // ---------------------------------------------------------------
   always_comb begin
      count_in           = count_ff;
      reading_in         = reading_ff;
      read_left_in       = read_left_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_data_out_in    = rsp_data_out_ff;
      rsp_count_out_in   = rsp_count_out_ff;
      rsp_last_result_in = rsp_last_result_ff;
      do_insert          = 1'b0;
      do_delete          = 1'b0;
      do_rotate          = 1'b0;

      if (reading_ff && out_free) begin
         // stream head entry, rotate the ring by one
         do_rotate          = 1'b1;
         rsp_valid_in       = 1'b1;
         rsp_status_in      = ST_OK;
         rsp_data_out_in    = entry_vals[0];
         rsp_count_out_in   = COUNT_OUT_W'(count_ff);
         rsp_last_result_in = (read_left_ff == CNT_W'(1));
         read_left_in       = read_left_ff - CNT_W'(1);
         if (read_left_ff == CNT_W'(1)) begin
            reading_in = 1'b0;
         end
      end else if (req_accept) begin
         rsp_valid_in       = 1'b1;
         rsp_status_in      = ST_OK;
         rsp_data_out_in    = '0;
         rsp_last_result_in = 1'b1;
         case (req_op)
            OP_INSERT: begin
               // full is checked ahead of the position
               if (cnt_ext >= CMP_W'(CAPACITY)) begin
                  rsp_status_in = ST_FULL;
               end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  do_insert = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            OP_DELETE: begin
               if (pos_ext == '0 || pos_ext > cnt_ext) begin
                  rsp_status_in = ST_RANGE;
               end else begin
                  do_delete = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            OP_READ: begin
               if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
               end else begin
                  // no response now; entries stream once the read state is registered
                  rsp_valid_in = rsp_valid_ff && rsp_stall;
                  reading_in   = 1'b1;
                  read_left_in = count_ff;
               end
            end
            default: begin
               // unused opcode: plain ok, list untouched
               rsp_status_in = ST_OK;
            end
         endcase
         rsp_count_out_in = COUNT_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         reading_ff   <= 1'b0;
         read_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         reading_ff   <= reading_in;
         read_left_ff <= read_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff      <= rsp_status_in;
      rsp_data_out_ff    <= rsp_data_out_in;
      rsp_count_out_ff   <= rsp_count_out_in;
      rsp_last_result_ff <= rsp_last_result_in;
   end

   // ---------------------------------------------------------------
   // cell row: each cell picks its own move from its index
   // ---------------------------------------------------------------
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      cell_op_type              op_sel;
      logic signed [DATA_W-1:0] left_val;
      logic signed [DATA_W-1:0] right_val;

      always_comb begin
         op_sel = CELL_HOLD;
         if (do_insert) begin
            if (CMP_W'(g) > idx_k) begin
               op_sel = CELL_LEFT;
            end else if (CMP_W'(g) == idx_k) begin
               op_sel = CELL_LOAD;
            end
         end else if (do_delete) begin
            if (CMP_W'(g) >= idx_k && CMP_W'(g + 1) < cnt_ext) begin
               op_sel = CELL_RIGHT;
            end
         end else if (do_rotate) begin
            if (CMP_W'(g + 1) < cnt_ext) begin
               op_sel = CELL_RIGHT;
            end else if (CMP_W'(g + 1) == cnt_ext) begin
               op_sel = CELL_HEAD;
            end
         end
      end

      // ends of the row: no lower neighbor at cell 0, ring wrap at the top
      if (g == 0) begin : g_first
         assign left_val = req_value;
      end else begin : g_mid_l
         assign left_val = entry_vals[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_val = entry_vals[0];
      end else begin : g_mid_r
         assign right_val = entry_vals[g+1];
      end

      plin_cell u_cell (
         .clock     (clock),
         .op        (op_sel),
         .new_val   (req_value),
         .left_val  (left_val),
         .right_val (right_val),
         .head_val  (entry_vals[0]),
         .entry     (entry_vals[g])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_out_ff;
   assign rsp_count_out   = rsp_count_out_ff;
   assign rsp_last_result = rsp_last_result_ff;

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_mid_only_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_result_ff |-> reading_ff)
      else $error("non-final response outside a read stream");

   a_read_count_stable: assert property (@(posedge clock) disable iff (reset)
      reading_ff |=> count_ff == $past(count_ff))
      else $error("count changed during read stream");

   a_read_left: assert property (@(posedge clock) disable iff (reset)
      reading_ff |-> read_left_ff != '0 && read_left_ff <= count_ff)
      else $error("read counter out of step with count");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the positional list
// Drives insert, delete and read requests through the valid/stall channel,
// predicts responses from a queue-based list copy or the table, and compares
// each accepted response field by field, in order, under varied idling.
// ----------------------------------------------------------------------------
module tb;
   import plin_pkg::*;

   localparam int         LIST_CAP  = CAPACITY_DEF;
   // opcode 3 has no operation behind it; the block answers it like a no-op
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // one response as the block presents it
   typedef struct {
      status_type         status;
      logic signed [31:0] data;
      logic [4:0]         count;
      logic               last;
   } list_rsp_type;

   // one row of the directed table; reps > 1 repeats the row with value + k
   typedef struct packed {
      logic [1:0]  opcode;
      logic [4:0]  position;
      logic [31:0] value;
      logic [4:0]  reps;
      logic        typed;        // expected response given in the row itself
      status_type  exp_status;
      logic [4:0]  exp_count;
   } directed_row_type;

   // Directed part: empty list cases first, then the only-entry delete, a
   // fill to capacity, full and out-of-range errors, and reads in between.
   localparam directed_row_type DIRECTED [16] = '{
      '{OP_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY, 5'd0},
      '{OP_DELETE, 5'd1,  32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 5'd0},
      '{OP_INSERT, 5'd0,  32'h1234_5678, 5'd1,  1'b1, ST_RANGE, 5'd0},
      '{OP_UNUSED, 5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,    5'd0},
      '{OP_INSERT, 5'd1,  32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,    5'd1},
      '{OP_DELETE, 5'd1,  32'h0000_0000, 5'd1,  1'b1, ST_OK,    5'd0},
      '{OP_INSERT, 5'd2,  32'h0000_0001, 5'd1,  1'b1, ST_RANGE, 5'd0},
      '{OP_INSERT, 5'd1,  32'h8000_0000, 5'd1,  1'b1, ST_OK,    5'd1},
      '{OP_INSERT, 5'd2,  32'hFFFF_FFFF, 5'd15, 1'b0, ST_OK,    5'd0},
      '{OP_INSERT, 5'd17, 32'h5555_5555, 5'd1,  1'b1, ST_FULL,  5'd16},
      '{OP_READ,   5'd31, 32'hFFFF_FFFF, 5'd1,  1'b0, ST_OK,    5'd0},
      '{OP_DELETE, 5'd31, 32'h0000_0000, 5'd1,  1'b1, ST_RANGE, 5'd16},
      '{OP_DELETE, 5'd16, 32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0},
      '{OP_DELETE, 5'd1,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0},
      '{OP_INSERT, 5'd15, 32'hAAAA_AAAA, 5'd1,  1'b0, ST_OK,    5'd0},
      '{OP_READ,   5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,    5'd0}
   };

   logic               clock           = 1'b0;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic [1:0]         req_opcode      = '0;
   logic [4:0]         req_position    = '0;
   logic signed [31:0] req_value       = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data_out;
   logic [4:0]         rsp_count_out;
   logic               rsp_last_result;

   // list contents as the block should hold them, head first
   logic signed [31:0] list_model [$];
   // responses of the request being predicted
   list_rsp_type       step_rsp [$];
   // responses still owed by the block, oldest first
   list_rsp_type       expected_rsp [$];
   // responses taken from the block this cycle, compared at the falling edge
   list_rsp_type       taken_rsp [$];

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int fill_goal      = 8;

   positional_list_insert_delete_top #(
      .CAPACITY(LIST_CAP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_count_out  (rsp_count_out),
      .rsp_last_result(rsp_last_result)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // generous time limit for the whole run
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // count_out always reflects the list after the operation
   function automatic void push_rsp(input status_type st, input logic signed [31:0] d,
                                    input logic lst);
      step_rsp.push_back('{st, d, 5'(list_model.size()), lst});
   endfunction

   // Applies one request to the shadow list and collects its responses.
   function automatic void predict_list_op(input logic [1:0] op, input logic [4:0] pos,
                                           input logic signed [31:0] val);
      int n;
      n = list_model.size();
      step_rsp.delete();
      case (op)
         OP_INSERT: begin
            // a full list is reported before the position is looked at
            if (n >= LIST_CAP) push_rsp(ST_FULL, '0, 1'b1);
            else if (pos < 1 || pos > n + 1) push_rsp(ST_RANGE, '0, 1'b1);
            else begin
               list_model.insert(int'(pos) - 1, val);
               push_rsp(ST_OK, '0, 1'b1);
            end
         end
         OP_DELETE: begin
            if (pos < 1 || pos > n) push_rsp(ST_RANGE, '0, 1'b1);
            else begin
               list_model.delete(int'(pos) - 1);
               push_rsp(ST_OK, '0, 1'b1);
            end
         end
         OP_READ: begin
            if (n == 0) push_rsp(ST_EMPTY, '0, 1'b1);
            else for (int i = 0; i < n; i++) push_rsp(ST_OK, list_model[i], i == n - 1);
         end
         default: push_rsp(ST_OK, '0, 1'b1);
      endcase
   endfunction

   // Presents one request, holds it until accepted, then books its responses.
   // Called at a rising edge; every drive is a single NBA in its time step.
   task automatic send_request(input logic [1:0] op, input logic [4:0] pos,
                               input logic signed [31:0] val, input logic typed,
                               input status_type t_status, input logic [4:0] t_count);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_list_op(op, pos, val);
      if (typed) expected_rsp.push_back('{t_status, 32'sd0, t_count, 1'b1});
      else foreach (step_rsp[i]) expected_rsp.push_back(step_rsp[i]);
   endtask

   // Random requests, mostly well formed. The list is steered toward a
   // moving fill goal so it spends time both empty and full; about one
   // position in seven is drawn from the whole field to hit range errors.
   task automatic run_random(input int n_items);
      logic [1:0]         op;
      logic [4:0]         pos;
      logic signed [31:0] val;
      int                 n;
      int                 roll;
      for (int i = 0; i < n_items; i++) begin
         n = list_model.size();
         if (n == fill_goal) fill_goal = $urandom_range(LIST_CAP, 0);
         roll = $urandom_range(99);
         if (roll < 8) op = OP_READ;
         else if (roll < 11) op = OP_UNUSED;
         else if ((n < fill_goal) == ($urandom_range(99) < 80)) op = OP_INSERT;
         else op = OP_DELETE;
         if ($urandom_range(99) < 15) pos = 5'($urandom_range(31, 0));
         else if (op == OP_INSERT) pos = 5'($urandom_range(n + 1, 1));
         else pos = (n == 0) ? 5'd1 : 5'($urandom_range(n, 1));
         case ($urandom_range(9))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = 32'h0000_0000;
            3:       val = 32'hFFFF_FFFF;
            default: val = $urandom();
         endcase
         send_request(op, pos, val, 1'b0, ST_OK, '0);
      end
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // capture at the edge, values as the block saw them
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         taken_rsp.push_back('{status_type'(rsp_status), rsp_data_out, rsp_count_out,
                               rsp_last_result});
   end

   // compare at the falling edge, when both queues are settled for this edge
   always @(negedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (taken_rsp.size() > 0) begin
         got = taken_rsp.pop_front();
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected response, status", 32'(got.status), '0);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.data !== want.data)
               report_mismatch("data_out", got.data, want.data);
            if (got.count !== want.count)
               report_mismatch("count_out", 32'(got.count), 32'(want.count));
            if (got.last !== want.last)
               report_mismatch("last_result", 32'(got.last), 32'(want.last));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling on either side
      foreach (DIRECTED[i]) begin
         for (int k = 0; k < DIRECTED[i].reps; k++)
            send_request(DIRECTED[i].opcode, DIRECTED[i].position,
                         DIRECTED[i].value + k, DIRECTED[i].typed,
                         DIRECTED[i].exp_status, DIRECTED[i].exp_count);
      end

      // random phases: clean, sender gaps, receiver stalls, both
      send_idle_pct = 0;  stall_pct = 0;  run_random(120);
      send_idle_pct = 50; stall_pct = 0;  run_random(120);
      send_idle_pct = 0;  stall_pct = 50; run_random(120);
      send_idle_pct = 16; stall_pct = 16; run_random(120);

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      // room for any stray response to show up
      repeat (40) @(posedge clock);

      if (mismatch_count == 0 && expected_rsp.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
